[sv/sfpp_pkg.sv]
package sfpp_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned AddrWidth  = 4;
   localparam int unsigned DataWidth  = 32;

   localparam logic [ByteWidth-1:0] SyncHighReset  = 8'd83;
   localparam logic [ByteWidth-1:0] SyncLowReset   = 8'd121;
   localparam logic [ByteWidth-1:0] MaxLengthReset = 8'd255;

   typedef enum logic [1:0] {
      REG_SYNC_HIGH  = 2'd0,
      REG_SYNC_LOW   = 2'd1,
      REG_MAX_LENGTH = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_DATA    = 3'd1,
      EV_ACCEPT  = 3'd2,
      EV_BADSUM  = 3'd3,
      EV_INVALID = 3'd4
   } event_type;

   typedef struct packed {
      logic [ByteWidth-1:0] sync_high;
      logic [ByteWidth-1:0] sync_low;
      logic [ByteWidth-1:0] max_length;
   } cfg_type;

   typedef struct packed {
      event_type            event_res;
      logic [ByteWidth-1:0] payload_byte;
      logic [ByteWidth-1:0] byte_index;
      logic [ByteWidth-1:0] frame_command;
      logic [ByteWidth-1:0] frame_length;
   } result_type;

endpackage

[sv/sfpp_csr.sv]
module sfpp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sfpp_pkg::AddrWidth-1:0]     paddr,
   input  logic [sfpp_pkg::DataWidth-1:0]     pwdata,
   output logic [sfpp_pkg::DataWidth-1:0]     prdata,
   output logic                               pready,
   output sfpp_pkg::cfg_type                  cfg
);

   sfpp_pkg::cfg_type cfg_ff;
   logic [sfpp_pkg::ByteWidth-1:0] wbyte;
   logic [sfpp_pkg::ByteWidth-1:0] rbyte;
   logic wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign wbyte  = pwdata[sfpp_pkg::ByteWidth-1:0];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_high  <= sfpp_pkg::SyncHighReset;
         cfg_ff.sync_low   <= sfpp_pkg::SyncLowReset;
         cfg_ff.max_length <= sfpp_pkg::MaxLengthReset;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            sfpp_pkg::REG_SYNC_HIGH:  cfg_ff.sync_high  <= wbyte;
            sfpp_pkg::REG_SYNC_LOW:   cfg_ff.sync_low   <= wbyte;
            sfpp_pkg::REG_MAX_LENGTH: cfg_ff.max_length <= wbyte;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         sfpp_pkg::REG_SYNC_HIGH:  rbyte = cfg_ff.sync_high;
         sfpp_pkg::REG_SYNC_LOW:   rbyte = cfg_ff.sync_low;
         sfpp_pkg::REG_MAX_LENGTH: rbyte = cfg_ff.max_length;
         default:                  rbyte = '0;
      endcase
   end

   assign prdata = {{(sfpp_pkg::DataWidth-sfpp_pkg::ByteWidth){1'b0}}, rbyte};

endmodule

[sv/sfpp_parser.sv]
module sfpp_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  sfpp_pkg::cfg_type               cfg,
   input  logic                            step,
   input  logic [sfpp_pkg::ByteWidth-1:0]  rx_byte,
   output sfpp_pkg::result_type            result
);

   typedef enum logic [2:0] {
      PH_SYNC0 = 3'd0,
      PH_SYNC1 = 3'd1,
      PH_CMD   = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_SUMH  = 3'd5,
      PH_SUML  = 3'd6
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  sum_high_ff, sum_high_in;

   sfpp_pkg::event_type ev;
   logic [7:0] pbyte;
   logic [7:0] pidx;

   // Fletcher step: high byte accumulates data, low byte accumulates new high
   function automatic logic [15:0] sum_add(input logic [15:0] sum, input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = sum[15:8] + b;
      lo = sum[7:0] + hi;
      return {hi, lo};
   endfunction

   always_comb begin
      phase_in    = phase_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      sum_high_in = sum_high_ff;
      ev          = sfpp_pkg::EV_NONE;
      pbyte       = '0;
      pidx        = '0;
      unique case (phase_ff)
         PH_SYNC1: begin
            if (rx_byte == cfg.sync_low) begin
               phase_in = PH_CMD;
            end else if (rx_byte != cfg.sync_high) begin
               phase_in = PH_SYNC0;
            end
         end
         PH_CMD: begin
            command_in = rx_byte;
            sum_in     = sum_add(16'd0, rx_byte);
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            if (rx_byte > cfg.max_length) begin
               ev       = sfpp_pkg::EV_INVALID;
               phase_in = PH_SYNC0;
            end else begin
               length_in = rx_byte;
               count_in  = '0;
               sum_in    = sum_add(sum_ff, rx_byte);
               phase_in  = (rx_byte != 8'd0) ? PH_DATA : PH_SUMH;
            end
         end
         PH_DATA: begin
            ev       = sfpp_pkg::EV_DATA;
            pbyte    = rx_byte;
            pidx     = count_ff;
            sum_in   = sum_add(sum_ff, rx_byte);
            count_in = count_ff + 8'd1;
            if (count_in == length_ff) begin
               phase_in = PH_SUMH;
            end
         end
         PH_SUMH: begin
            sum_high_in = rx_byte;
            phase_in    = PH_SUML;
         end
         PH_SUML: begin
            ev = ({sum_high_ff, rx_byte} == sum_ff) ? sfpp_pkg::EV_ACCEPT
                                                    : sfpp_pkg::EV_BADSUM;
            phase_in = PH_SYNC0;
         end
         default: begin
            // sync hunt; unused phase codes land here too
            phase_in = (rx_byte == cfg.sync_high) ? PH_SYNC1 : PH_SYNC0;
         end
      endcase
   end

   always_comb begin
      result.event_res     = ev;
      result.payload_byte  = pbyte;
      result.byte_index    = pidx;
      result.frame_command = command_in;
      result.frame_length  = (ev == sfpp_pkg::EV_INVALID) ? rx_byte : length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC0;
         command_ff  <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
         sum_high_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         command_ff  <= command_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         sum_high_ff <= sum_high_in;
      end
   end

endmodule

[sv/sync_framed_packet_parser_core.sv]
// channel   direction  handshake         payload
// req       in         req_valid/stall   rx_byte
// rsp       out        rsp_valid/stall   event_res, payload_byte, byte_index,
//                                        frame_command, frame_length
// csr       in/out     APB               sync_high, sync_low, max_length
//
// One byte per cycle sustained while rsp_stall is low; each byte gives exactly one result word.
// Each byte passes through the input register, then the parse step into the result register.
// Synchronous reset puts the parser in sync hunt and loads the register defaults.
// A stalled result holds; one more byte is taken into the input register, then
// req_stall rises until the result is taken.
module sync_framed_packet_parser_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_event_res,
   output logic [7:0]                       rsp_payload_byte,
   output logic [7:0]                       rsp_byte_index,
   output logic [7:0]                       rsp_frame_command,
   output logic [7:0]                       rsp_frame_length,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sfpp_pkg::AddrWidth-1:0]   csr_paddr,
   input  logic [sfpp_pkg::DataWidth-1:0]   csr_pwdata,
   output logic [sfpp_pkg::DataWidth-1:0]   csr_prdata,
   output logic                             csr_pready
);

   sfpp_pkg::cfg_type    cfg;
   sfpp_pkg::result_type result;
   sfpp_pkg::result_type out_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       advance;
   logic       in_load;

   sfpp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sfpp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   // word moves from input register to result register
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign in_load   = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = out_ff.event_res;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_byte_index    = out_ff.byte_index;
   assign rsp_frame_command = out_ff.frame_command;
   assign rsp_frame_length  = out_ff.frame_length;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CycleLimit = 200000;

   typedef enum logic [2:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      TAKE_COMMAND,
      TAKE_LENGTH,
      TAKE_PAYLOAD,
      TAKE_SUM_HIGH,
      TAKE_SUM_LOW
   } parse_phase_type;

   typedef logic [7:0] byte_list_type [$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_byte_index;
   logic [7:0]  rsp_frame_command;
   logic [7:0]  rsp_frame_length;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [sfpp_pkg::AddrWidth-1:0] csr_paddr;
   logic [sfpp_pkg::DataWidth-1:0] csr_pwdata;
   logic [sfpp_pkg::DataWidth-1:0] csr_prdata;
   logic        csr_pready;

   // parser model state and register shadow
   sfpp_pkg::cfg_type cfg;
   parse_phase_type   phase;
   logic [7:0]        cur_command;
   logic [7:0]        cur_length;
   logic [7:0]        payload_seen;
   logic [15:0]       fletcher_sum;
   logic [7:0]        sum_high_seen;

   sfpp_pkg::result_type pending_results [$];
   int unsigned     error_count = 0;
   int unsigned     items_sent = 0;
   int unsigned     cycle_count = 0;
   int unsigned     hold_cycles_req = 0;
   bit              sender_idles = 1'b1;
   bit              receiver_idles = 1'b1;

   sync_framed_packet_parser_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // high byte sums the data, low byte sums the new high byte, both mod 256
   function automatic logic [15:0] fletcher_step(input logic [15:0] sum, input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = sum[15:8] + b;
      lo = sum[7:0] + hi;
      return {hi, lo};
   endfunction

   function automatic sfpp_pkg::result_type predict_result(input logic [7:0] c);
      sfpp_pkg::result_type r;
      r = '0;
      r.event_res = sfpp_pkg::EV_NONE;
      case (phase)
         HUNT_SECOND: begin
            // second byte match wins when both sync bytes are equal
            if (c == cfg.sync_low) phase = TAKE_COMMAND;
            else if (c != cfg.sync_high) phase = HUNT_FIRST;
         end
         TAKE_COMMAND: begin
            cur_command = c;
            fletcher_sum = fletcher_step(16'h0000, c);
            phase = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            if (c > cfg.max_length) begin
               r.event_res = sfpp_pkg::EV_INVALID;
               phase = HUNT_FIRST;
            end else begin
               cur_length = c;
               payload_seen = 8'd0;
               fletcher_sum = fletcher_step(fletcher_sum, c);
               phase = (c != 8'd0) ? TAKE_PAYLOAD : TAKE_SUM_HIGH;
            end
         end
         TAKE_PAYLOAD: begin
            r.event_res = sfpp_pkg::EV_DATA;
            r.payload_byte = c;
            r.byte_index = payload_seen;
            fletcher_sum = fletcher_step(fletcher_sum, c);
            payload_seen = payload_seen + 8'd1;
            if (payload_seen == cur_length) phase = TAKE_SUM_HIGH;
         end
         TAKE_SUM_HIGH: begin
            sum_high_seen = c;
            phase = TAKE_SUM_LOW;
         end
         TAKE_SUM_LOW: begin
            r.event_res = ({sum_high_seen, c} == fletcher_sum) ? sfpp_pkg::EV_ACCEPT
                                                               : sfpp_pkg::EV_BADSUM;
            phase = HUNT_FIRST;
         end
         default: begin
            phase = (c == cfg.sync_high) ? HUNT_SECOND : HUNT_FIRST;
         end
      endcase
      r.frame_command = cur_command;
      r.frame_length = (r.event_res == sfpp_pkg::EV_INVALID) ? c : cur_length;
      return r;
   endfunction

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : result_checker
      sfpp_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report($sformatf("result word with none expected, event %0d", rsp_event_res));
            end else begin
               want = pending_results.pop_front();
               if (rsp_event_res !== want.event_res)
                  report($sformatf("event_res got %0d expected %0d",
                                   rsp_event_res, want.event_res));
               if (rsp_payload_byte !== want.payload_byte)
                  report($sformatf("payload_byte got %0h expected %0h",
                                   rsp_payload_byte, want.payload_byte));
               if (rsp_byte_index !== want.byte_index)
                  report($sformatf("byte_index got %0d expected %0d",
                                   rsp_byte_index, want.byte_index));
               if (rsp_frame_command !== want.frame_command)
                  report($sformatf("frame_command got %0h expected %0h",
                                   rsp_frame_command, want.frame_command));
               if (rsp_frame_length !== want.frame_length)
                  report($sformatf("frame_length got %0d expected %0d",
                                   rsp_frame_length, want.frame_length));
            end
         end
         if (req_valid && !req_stall) pending_results.push_back(predict_result(req_rx_byte));
      end
   end

   // receiver: random stall bursts, plus a long hold when a test asks for one
   always begin
      @(negedge clock);
      if (hold_cycles_req != 0) begin
         rsp_stall <= 1'b1;
         repeat (hold_cycles_req) @(negedge clock);
         hold_cycles_req = 0;
         rsp_stall <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 15)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (sender_idles && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input sfpp_pkg::reg_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'h000000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         sfpp_pkg::REG_SYNC_HIGH:  cfg.sync_high = value;
         sfpp_pkg::REG_SYNC_LOW:   cfg.sync_low = value;
         sfpp_pkg::REG_MAX_LENGTH: cfg.max_length = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] sync_high, input logic [7:0] sync_low,
                                 input logic [7:0] max_length);
      drain_pipeline();
      write_reg(sfpp_pkg::REG_SYNC_HIGH, sync_high);
      write_reg(sfpp_pkg::REG_SYNC_LOW, sync_low);
      write_reg(sfpp_pkg::REG_MAX_LENGTH, max_length);
   endtask

   // full frame with the correct checksum unless corrupt is set; a length over the
   // limit ends after the length byte since the parser drops back to the hunt
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                             input byte_list_type payload, input bit corrupt,
                             input int unsigned extra_syncs);
      logic [15:0] sum;
      repeat (extra_syncs) send_byte(cfg.sync_high);
      send_byte(cfg.sync_high);
      send_byte(cfg.sync_low);
      send_byte(cmd);
      send_byte(len);
      if (len > cfg.max_length) return;
      sum = fletcher_step(fletcher_step(16'h0000, cmd), len);
      foreach (payload[i]) begin
         send_byte(payload[i]);
         sum = fletcher_step(sum, payload[i]);
      end
      if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
      send_byte(sum[15:8]);
      send_byte(sum[7:0]);
   endtask

   function automatic logic [7:0] pick_length();
      int unsigned r;
      int unsigned cap;
      r = $urandom_range(0, 39);
      cap = (cfg.max_length < 12) ? cfg.max_length : 12;
      if (r == 0) return cfg.max_length;
      if (r == 1) return 8'($urandom_range(0, cfg.max_length));
      return 8'($urandom_range(0, cap));
   endfunction

   function automatic byte_list_type random_payload(input int unsigned n);
      byte_list_type q;
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   // mostly well-formed frames with random content, the rest noise and broken frames
   task automatic send_random_mix(input int unsigned count);
      int unsigned start;
      int unsigned pick;
      int unsigned extra;
      logic [7:0]  len;
      byte_list_type no_payload;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(0, 99);
         len = pick_length();
         if (pick < 8 && cfg.max_length != 8'hFF) begin
            send_frame(8'($urandom_range(0, 255)),
                       8'($urandom_range(cfg.max_length + 1, 255)), no_payload, 1'b0, 0);
         end else if (pick < 16) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 22) begin
            // frame cut short; what follows lands in its payload or checksum
            send_byte(cfg.sync_high);
            send_byte(cfg.sync_low);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(len);
            repeat ($urandom_range(0, (len > 4) ? 4 : len)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            extra = (cfg.sync_high != cfg.sync_low && pick % 5 == 0) ? $urandom_range(1, 3) : 0;
            send_frame(8'($urandom_range(0, 255)), len, random_payload(len), pick < 35, extra);
         end
      end
   endtask

   task automatic test_directed();
      byte_list_type no_payload;
      byte_list_type extremes;
      extremes = {8'hFF, 8'h00};
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'hFF, 8'd0, no_payload, 1'b0, 1);
      send_frame(8'h00, 8'd2, extremes, 1'b1, 0);
      send_frame(8'h5A, 8'd2, extremes, 1'b0, 0);
   endtask

   task automatic test_register_settings();
      byte_list_type no_payload;
      apply_settings(8'h00, 8'hFF, 8'd0);
      send_frame(8'h12, 8'd1, no_payload, 1'b0, 0);
      send_frame(8'h34, 8'd0, no_payload, 1'b0, 0);
      send_random_mix(120);
      apply_settings(8'hFF, 8'h00, 8'd255);
      send_random_mix(150);
      // equal sync bytes
      apply_settings(8'hAA, 8'hAA, 8'd16);
      send_random_mix(150);
      apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      send_random_mix(150);
      apply_settings(sfpp_pkg::SyncHighReset, sfpp_pkg::SyncLowReset, 8'd40);
   endtask

   task automatic test_backpressure();
      hold_cycles_req = 300;
      send_random_mix(150);
   endtask

   task automatic test_random_traffic();
      send_random_mix(650);
   endtask

   task automatic test_steady_stream();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      send_random_mix(250);
   endtask

   initial begin
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg.sync_high = sfpp_pkg::SyncHighReset;
      cfg.sync_low = sfpp_pkg::SyncLowReset;
      cfg.max_length = sfpp_pkg::MaxLengthReset;
      phase = HUNT_FIRST;
      cur_command = 8'd0;
      cur_length = 8'd0;
      payload_seen = 8'd0;
      fletcher_sum = 16'd0;
      sum_high_seen = 8'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_register_settings();
      test_backpressure();
      test_random_traffic();
      test_steady_stream();
      drain_pipeline();

      if (pending_results.size() != 0)
         report($sformatf("%0d result words never arrived", pending_results.size()));
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
sv/sfpp_pkg.sv
sv/sfpp_csr.sv
sv/sfpp_parser.sv
sv/sync_framed_packet_parser_core.sv
tb/sv/testbench.sv
